FILE: rtl/mabsg_pkg.sv
package mabsg_pkg;

    // number of axes that have fields on the ports
    localparam int FIELD_AXES = 4;
    localparam int POS_W      = 32;
    localparam int TICK_W     = 8;
    localparam int SEG_W      = POS_W + TICK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INVERT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT  = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_TICK   = 2'd0,
        ST_QUEUED = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOMOVE = 2'd3
    } push_status_t;

    typedef struct packed {
        logic rd_issue;
        logic capture;
        logic push_calc;
        logic push_write;
        logic tick_calc;
        logic tick_exec;
        logic load;
        logic exec;
    } lane_ctrl_t;

    typedef struct packed {
        logic [POS_W-1:0] distance;
        logic [POS_W-1:0] pos;
        logic             step;
        logic             dir;
    } lane_stat_t;

endpackage

FILE: rtl/mabsg_cmd_if.sv
interface mabsg_cmd_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] target_axis0;
    logic signed [31:0] target_axis1;
    logic signed [31:0] target_axis2;
    logic signed [31:0] target_axis3;

    modport source (
        output valid, req_type, target_axis0, target_axis1, target_axis2, target_axis3,
        input  ready
    );
    modport sink (
        input  valid, req_type, target_axis0, target_axis1, target_axis2, target_axis3,
        output ready
    );
endinterface

FILE: rtl/mabsg_res_if.sv
interface mabsg_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         step_levels;
    logic [3:0]         dir_levels;
    logic [1:0]         push_status;
    logic               segment_active;
    logic               segment_done;
    logic signed [31:0] pos_axis0;
    logic signed [31:0] pos_axis1;
    logic signed [31:0] pos_axis2;
    logic signed [31:0] pos_axis3;

    modport source (
        output valid, step_levels, dir_levels, push_status, segment_active, segment_done,
               pos_axis0, pos_axis1, pos_axis2, pos_axis3,
        input  ready
    );
    modport sink (
        input  valid, step_levels, dir_levels, push_status, segment_active, segment_done,
               pos_axis0, pos_axis1, pos_axis2, pos_axis3,
        output ready
    );
endinterface

FILE: rtl/mabsg_cfg_if.sv
interface mabsg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/mabsg_ram.sv
module mabsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mabsg_lane.sv
module mabsg_lane #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mabsg_pkg::lane_ctrl_t          ctrl,
    input  logic                           enable,
    input  logic [mabsg_pkg::POS_W-1:0]    target,
    input  logic [mabsg_pkg::POS_W-1:0]    seed,
    input  logic [mabsg_pkg::POS_W-1:0]    event_count,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
    output mabsg_pkg::lane_stat_t          stat
);

    localparam int W  = mabsg_pkg::POS_W;
    localparam int LW = W + 1;

    logic [W-1:0]  target_reg;
    logic [W-1:0]  pos_reg;
    logic [W-1:0]  acc_reg;
    logic [W:0]    sum_reg;
    logic          part_reg;
    logic          step_reg;
    logic          dir_reg;
    logic [W-1:0]  dist_reg;
    logic          dirp_reg;

    logic [LW-1:0] rd_data;
    logic [W-1:0]  rd_steps;
    logic          rd_dir;
    logic [W-1:0]  acc_base;
    logic          part;
    logic [W:0]    sum_next;
    logic [W+1:0]  diff;
    logic          step;
    logic [W:0]    d_ab;
    logic [W:0]    d_ba;
    logic [W-1:0]  mag;
    logic          dirp;

    mabsg_ram #(
        .WIDTH (LW),
        .DEPTH (QUEUE_DEPTH)
    ) u_steps_ram (
        .clk   (clk),
        .we    (ctrl.push_write),
        .waddr (waddr),
        .wdata ({dirp_reg, dist_reg}),
        .re    (ctrl.rd_issue),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign rd_steps = rd_data[W-1:0];
    assign rd_dir   = rd_data[W];

    // bresenham add, seeded with half the event count on segment load
    always_comb
    begin
        acc_base = ctrl.load ? seed : acc_reg;
        part     = ctrl.exec && enable && (rd_steps != '0);
        sum_next = part ? ({1'b0, acc_base} + {1'b0, rd_steps}) : {1'b0, acc_base};
    end

    // step when the sum exceeds the event count
    always_comb
    begin
        diff = {1'b0, sum_reg} - {2'b00, event_count};
        step = part_reg && !diff[W+1] && (diff[W:0] != '0);
    end

    // signed distance to target, 33 bits so it never overflows
    always_comb
    begin
        d_ab = {target_reg[W-1], target_reg} - {pos_reg[W-1], pos_reg};
        d_ba = {pos_reg[W-1], pos_reg} - {target_reg[W-1], target_reg};
        mag  = d_ab[W] ? d_ba[W-1:0] : d_ab[W-1:0];
        dirp = !d_ab[W] && (mag != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            target_reg <= target;
        end
        if (ctrl.tick_calc)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.push_calc)
        begin
            dist_reg <= enable ? mag : '0;
            dirp_reg <= enable && dirp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            acc_reg  <= '0;
            part_reg <= 1'b0;
            step_reg <= 1'b0;
            dir_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.tick_calc)
            begin
                part_reg <= part;
                if (ctrl.load)
                begin
                    dir_reg <= rd_dir;
                end
            end
            if (ctrl.tick_exec)
            begin
                step_reg <= ctrl.exec && step;
                if (ctrl.exec)
                begin
                    acc_reg <= step ? diff[W-1:0] : sum_reg[W-1:0];
                    if (step)
                    begin
                        pos_reg <= dir_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign stat.distance = dist_reg;
    assign stat.pos      = pos_reg;
    assign stat.step     = step_reg;
    assign stat.dir      = dir_reg;

endmodule

FILE: rtl/mabsg_merge.sv
module mabsg_merge #(
    parameter int SEGMENT_TICK_CAP = 255
) (
    input  logic [mabsg_pkg::FIELD_AXES-1:0][mabsg_pkg::POS_W-1:0] distances,
    output logic [mabsg_pkg::POS_W-1:0]                            max_dist,
    output logic [mabsg_pkg::TICK_W-1:0]                           tick_count
);

    localparam int W = mabsg_pkg::POS_W;
    localparam logic [W-1:0] CAP = W'(SEGMENT_TICK_CAP);

    logic [W-1:0] max01;
    logic [W-1:0] max23;

    // two-level max tree over the lanes
    always_comb
    begin
        max01      = (distances[0] > distances[1]) ? distances[0] : distances[1];
        max23      = (distances[2] > distances[3]) ? distances[2] : distances[3];
        max_dist   = (max01 > max23) ? max01 : max23;
        tick_count = (max_dist < CAP) ? max_dist[mabsg_pkg::TICK_W-1:0]
                                      : CAP[mabsg_pkg::TICK_W-1:0];
    end

endmodule

FILE: rtl/multi_axis_bresenham_step_generator_core.sv
// channel | dir | handshake     | payload
// cmd     | in  | valid / ready | req_type, target_axis0..3
// res     | out | valid / ready | step/dir levels, push_status, segment flags, pos_axis0..3
// cfg     | in  | valid / ready | index, data (always ready)
//
// a request's result is registered after the states S_CALC (lane work: queue read or
// distance), S_MERGE or S_EXEC (merge or bresenham update) and S_DONE (result register).
// one request at a time, so a new one is taken only once the last one has left S_DONE.
// a new request is taken while the previous result still waits on res.ready and
// then holds in its last state until the result register frees.
// rst_n clears positions, queue pointers and segment state; queue ram is not cleared.
module multi_axis_bresenham_step_generator_core #(
    parameter int NUM_AXES         = 4,
    parameter int QUEUE_DEPTH      = 8,
    parameter int SEGMENT_TICK_CAP = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    mabsg_cmd_if.sink          cmd,
    mabsg_res_if.source        res,
    mabsg_cfg_if.sink          cfg
);

    localparam int AXES_USED = (NUM_AXES < mabsg_pkg::FIELD_AXES) ? NUM_AXES
                                                                  : mabsg_pkg::FIELD_AXES;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int W     = mabsg_pkg::POS_W;
    localparam int TW    = mabsg_pkg::TICK_W;
    localparam int NA    = mabsg_pkg::FIELD_AXES;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CALC  = 5'b00010,
        S_MERGE = 5'b00100,
        S_EXEC  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;

    logic [3:0]              axis_en_reg;
    logic [3:0]              step_inv_reg;
    logic [3:0]              dir_inv_reg;

    logic                    is_push_reg;
    logic [PTR_W-1:0]        head_reg;
    logic [PTR_W-1:0]        tail_reg;
    logic                    running_reg;
    logic [TW-1:0]           ticks_left_reg;
    logic [W-1:0]            ev_reg;
    logic                    exec_reg;
    logic                    done_reg;
    mabsg_pkg::push_status_t status_reg;

    logic                    res_valid_reg;
    logic [3:0]              res_step_reg;
    logic [3:0]              res_dir_reg;
    logic [1:0]              res_status_reg;
    logic                    res_active_reg;
    logic                    res_done_reg;
    logic [NA-1:0][W-1:0]    res_pos_reg;

    logic                    cmd_accept;
    logic                    res_free;
    mabsg_pkg::lane_ctrl_t   ctrl;
    logic [NA-1:0][W-1:0]    cmd_target;
    mabsg_pkg::lane_stat_t   lane_stat [AXES_USED];
    logic [NA-1:0][W-1:0]    dist_all;
    logic [NA-1:0][W-1:0]    pos_all;
    logic [NA-1:0]           step_all;
    logic [NA-1:0]           dir_all;
    logic [W-1:0]            max_dist;
    logic [TW-1:0]           tick_count;
    logic [mabsg_pkg::SEG_W-1:0] seg_rdata;
    logic [W-1:0]            seg_ev;
    logic [TW-1:0]           seg_ticks;
    logic                    queue_full;
    logic                    queue_empty;
    logic                    load;
    logic                    exec;
    logic [TW-1:0]           ticks_cur;
    logic [TW-1:0]           ticks_dec;
    logic                    push_write;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign cfg.ready  = 1'b1;
    assign res_free   = !res_valid_reg || res.ready;

    assign cmd_target[0] = cmd.target_axis0;
    assign cmd_target[1] = cmd.target_axis1;
    assign cmd_target[2] = cmd.target_axis2;
    assign cmd_target[3] = cmd.target_axis3;

    // segment fields of the queue entry at the tail, valid in S_CALC
    assign seg_ev      = seg_rdata[mabsg_pkg::SEG_W-1:TW];
    assign seg_ticks   = seg_rdata[TW-1:0];
    assign queue_full  = (ring_next(head_reg) == tail_reg);
    assign queue_empty = (head_reg == tail_reg);

    always_comb
    begin
        load      = !running_reg && !queue_empty;
        exec      = running_reg || load;
        ticks_cur = load ? seg_ticks : ticks_left_reg;
        ticks_dec = (ticks_cur != '0) ? ticks_cur - 1'b1 : '0;
    end

    assign push_write = (state_reg == S_MERGE) && (max_dist != '0) && !queue_full;

    always_comb
    begin
        ctrl.rd_issue   = cmd_accept;
        ctrl.capture    = cmd_accept;
        ctrl.push_calc  = (state_reg == S_CALC) && is_push_reg;
        ctrl.push_write = push_write;
        ctrl.tick_calc  = (state_reg == S_CALC) && !is_push_reg;
        ctrl.tick_exec  = (state_reg == S_EXEC);
        ctrl.load       = load;
        ctrl.exec       = (state_reg == S_CALC) ? exec : exec_reg;
    end

    mabsg_ram #(
        .WIDTH (mabsg_pkg::SEG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_seg_ram (
        .clk   (clk),
        .we    (push_write),
        .waddr (head_reg),
        .wdata ({max_dist, tick_count}),
        .re    (cmd_accept),
        .raddr (tail_reg),
        .rdata (seg_rdata)
    );

    genvar gi;
    generate
        for (gi = 0; gi < NA; gi++)
        begin : g_axis
            if (gi < AXES_USED)
            begin : g_lane
                mabsg_lane #(
                    .QUEUE_DEPTH (QUEUE_DEPTH)
                ) u_lane (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .enable      (axis_en_reg[gi]),
                    .target      (cmd_target[gi]),
                    .seed        ({1'b0, seg_ev[W-1:1]}),
                    .event_count (ev_reg),
                    .waddr       (head_reg),
                    .raddr       (tail_reg),
                    .stat        (lane_stat[gi])
                );
                assign dist_all[gi] = lane_stat[gi].distance;
                assign pos_all[gi]  = lane_stat[gi].pos;
                assign step_all[gi] = lane_stat[gi].step;
                assign dir_all[gi]  = lane_stat[gi].dir;
            end
            else
            begin : g_unused
                assign dist_all[gi] = '0;
                assign pos_all[gi]  = '0;
                assign step_all[gi] = 1'b0;
                assign dir_all[gi]  = 1'b0;
            end
        end
    endgenerate

    mabsg_merge #(
        .SEGMENT_TICK_CAP (SEGMENT_TICK_CAP)
    ) u_merge (
        .distances  (dist_all),
        .max_dist   (max_dist),
        .tick_count (tick_count)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = is_push_reg ? S_MERGE : S_EXEC;
            end
            S_MERGE:
            begin
                state_next = S_DONE;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_en_reg    <= '0;
            step_inv_reg   <= '0;
            dir_inv_reg    <= '0;
            is_push_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            running_reg    <= 1'b0;
            ticks_left_reg <= '0;
            ev_reg         <= '0;
            exec_reg       <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= mabsg_pkg::ST_TICK;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    mabsg_pkg::CFG_AXIS_ENABLE: axis_en_reg  <= cfg.data;
                    mabsg_pkg::CFG_STEP_INVERT: step_inv_reg <= cfg.data;
                    mabsg_pkg::CFG_DIR_INVERT:  dir_inv_reg  <= cfg.data;
                    default:                    ;
                endcase
            end

            if (cmd_accept)
            begin
                is_push_reg <= (cmd.req_type == mabsg_pkg::REQ_PUSH);
            end

            // tick: load segment if idle, count down, retire on last tick
            if (ctrl.tick_calc)
            begin
                exec_reg <= exec;
                done_reg <= exec && (ticks_dec == '0);
                if (load)
                begin
                    ev_reg <= seg_ev;
                end
                if (exec)
                begin
                    ticks_left_reg <= ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        tail_reg    <= ring_next(tail_reg);
                        running_reg <= 1'b0;
                    end
                    else
                    begin
                        running_reg <= 1'b1;
                    end
                end
            end

            if (state_reg == S_MERGE)
            begin
                if (max_dist == '0)
                begin
                    status_reg <= mabsg_pkg::ST_NOMOVE;
                end
                else if (queue_full)
                begin
                    status_reg <= mabsg_pkg::ST_FULL;
                end
                else
                begin
                    status_reg <= mabsg_pkg::ST_QUEUED;
                    head_reg   <= ring_next(head_reg);
                end
            end

            if ((state_reg == S_DONE) && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && res_free)
        begin
            res_step_reg   <= (is_push_reg ? 4'b0000 : step_all) ^ step_inv_reg;
            res_dir_reg    <= dir_all ^ dir_inv_reg;
            res_status_reg <= is_push_reg ? status_reg : mabsg_pkg::ST_TICK;
            res_active_reg <= is_push_reg ? running_reg : exec_reg;
            res_done_reg   <= !is_push_reg && done_reg;
            res_pos_reg    <= pos_all;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.step_levels    = res_step_reg;
    assign res.dir_levels     = res_dir_reg;
    assign res.push_status    = res_status_reg;
    assign res.segment_active = res_active_reg;
    assign res.segment_done   = res_done_reg;
    assign res.pos_axis0      = res_pos_reg[0];
    assign res.pos_axis1      = res_pos_reg[1];
    assign res.pos_axis2      = res_pos_reg[2];
    assign res.pos_axis3      = res_pos_reg[3];

endmodule

FILE: rtl/mabsg_checker.sv
module mabsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  push_status,
    input logic        segment_active,
    input logic        segment_done,
    input logic [31:0] pos_axis0
);

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready
    ) else $error("request accepted while another is in flight");

    // a finished segment was being executed on that tick
    a_done_needs_active: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && segment_done) |-> segment_active
    ) else $error("segment_done without segment_active");

    // a push never finishes a segment
    a_push_no_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && (push_status != mabsg_pkg::ST_TICK)) |-> !segment_done
    ) else $error("segment_done on a push result");

    a_res_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(pos_axis0))
    ) else $error("stalled result changed");

endmodule

bind multi_axis_bresenham_step_generator_core mabsg_checker u_mabsg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .push_status    (res.push_status),
    .segment_active (res.segment_active),
    .segment_done   (res.segment_done),
    .pos_axis0      (res.pos_axis0)
);
